// File: src/wvo_pkg.sv
`timescale 1ns / 1ps
// shared types for the wheel velocity observation block
// no dependencies

package wvo_pkg;

    // lanes of the rotation divider, one per rotation entry, row-major
    localparam int NUM_LANES = 9;

    // magnitude of a rotation numerator or of the quaternion norm squared
    typedef logic [62:0] t_mag;

    // one signed 32-bit word
    typedef logic signed [31:0] t_word;

    // three velocity components
    typedef t_word t_vec [3];

    // control that travels along the divider pipeline
    typedef struct packed {
        logic valid;
        logic zero;
    } t_div_ctl;

endpackage

// File: src/wvo_divider.sv
`timescale 1ns / 1ps
// pipelined restoring divider, nine lanes sharing one divisor, one quotient bit a stage
// depends on wvo_pkg

module wvo_divider #(
    parameter int QUAT_FRAC_BITS = 30
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wvo_pkg::t_div_ctl   i_ctl,
    input  wvo_pkg::t_mag       i_n,
    input  wvo_pkg::t_mag       i_mag [wvo_pkg::NUM_LANES],
    input  logic [wvo_pkg::NUM_LANES-1:0] i_neg,
    output wvo_pkg::t_div_ctl   o_ctl,
    output wvo_pkg::t_word      o_rt  [wvo_pkg::NUM_LANES]
);

    localparam int QW = QUAT_FRAC_BITS + 1;
    localparam int NL = wvo_pkg::NUM_LANES;

    wvo_pkg::t_mag          r_rem [QUAT_FRAC_BITS+1][NL];
    logic [QW-1:0]          r_q   [QUAT_FRAC_BITS+1][NL];
    wvo_pkg::t_mag          r_n   [QUAT_FRAC_BITS+1];
    logic [NL-1:0]          r_neg [QUAT_FRAC_BITS+1];
    wvo_pkg::t_div_ctl      r_ctl [QUAT_FRAC_BITS+1];

    wvo_pkg::t_div_ctl      r_out_ctl;
    wvo_pkg::t_word         r_out_rt [NL];

    // integer bit of the quotient
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NL; l++) begin
            if (i_mag[l] >= i_n) begin
                r_rem[0][l] <= i_mag[l] - i_n;
                r_q[0][l]   <= QW'(1);
            end else begin
                r_rem[0][l] <= i_mag[l];
                r_q[0][l]   <= QW'(0);
            end
        end
        r_n[0]   <= i_n;
        r_neg[0] <= i_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else begin
            r_ctl[0] <= i_ctl;
        end
    end

    // fraction bits
    for (genvar k = 1; k <= QUAT_FRAC_BITS; k++) begin : g_step
        logic [63:0] rem2 [NL];
        logic [63:0] den;
        logic        ge   [NL];

        always_comb begin
            den = {1'b0, r_n[k-1]};
            for (int l = 0; l < NL; l++) begin
                rem2[l] = {r_rem[k-1][l], 1'b0};
                ge[l]   = (rem2[l] >= den);
            end
        end

        always_ff @(posedge i_clk) begin
            for (int l = 0; l < NL; l++) begin
                r_rem[k][l] <= ge[l] ? 63'(rem2[l] - den) : 63'(rem2[l]);
                r_q[k][l]   <= {r_q[k-1][l][QW-2:0], ge[l]};
            end
            r_n[k]   <= r_n[k-1];
            r_neg[k] <= r_neg[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    // round half away from zero, restore sign, identity on zero norm
    logic [63:0]    fin_rem2 [NL];
    logic [63:0]    fin_den;
    logic [QW:0]    fin_q    [NL];
    wvo_pkg::t_word fin_mag  [NL];
    wvo_pkg::t_word fin_rt   [NL];

    always_comb begin
        fin_den = {1'b0, r_n[QUAT_FRAC_BITS]};
        for (int l = 0; l < NL; l++) begin
            fin_rem2[l] = {r_rem[QUAT_FRAC_BITS][l], 1'b0};
            fin_q[l]    = (QW+1)'(r_q[QUAT_FRAC_BITS][l])
                        + (QW+1)'(fin_rem2[l] >= fin_den);
            fin_mag[l]  = 32'(fin_q[l]);
            if (r_ctl[QUAT_FRAC_BITS].zero) begin
                fin_rt[l] = (l == 0 || l == 4 || l == 8) ? (32'sd1 <<< QUAT_FRAC_BITS)
                                                         : 32'sd0;
            end else if (r_neg[QUAT_FRAC_BITS][l]) begin
                fin_rt[l] = -fin_mag[l];
            end else begin
                fin_rt[l] = fin_mag[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NL; l++) begin
            r_out_rt[l] <= fin_rt[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_ctl <= '0;
        end else begin
            r_out_ctl <= r_ctl[QUAT_FRAC_BITS];
        end
    end

    assign o_ctl = r_out_ctl;
    assign o_rt  = r_out_rt;

endmodule

// File: src/wheel_velocity_observation.sv
`timescale 1ns / 1ps
// wheel velocity observation top level: quaternion rotation of a velocity into the body frame
// depends on wvo_pkg and wvo_divider

// An item is taken when start is high and busy is low, also while earlier items are in
// flight. busy is high in the cycle after each acceptance and only then, however
// long start is held. Each item gives two rows on the result ports, row 0 then row 1 in
// the next cycle, each marked by o_valid for one cycle; the receiver cannot stall them.
// Most of the pipeline between acceptance and row 0 is the divider, which produces one
// quotient bit per stage for the nine rotation entries at once.

module wheel_velocity_observation #(
    parameter int QUAT_FRAC_BITS = 30
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [31:0]    i_quat_x,
    input  logic signed [31:0]    i_quat_y,
    input  logic signed [31:0]    i_quat_z,
    input  logic signed [31:0]    i_quat_w,
    input  logic signed [31:0]    i_fixed_vel_x,
    input  logic signed [31:0]    i_fixed_vel_y,
    input  logic signed [31:0]    i_fixed_vel_z,
    output logic                  o_valid,
    output logic                  o_row_index,
    output logic signed [31:0]    o_body_velocity,
    output logic signed [31:0]    o_rot_col0,
    output logic signed [31:0]    o_rot_col1,
    output logic signed [31:0]    o_rot_col2,
    output logic signed [31:0]    o_skew_col0,
    output logic signed [31:0]    o_skew_col1,
    output logic signed [31:0]    o_skew_col2,
    output logic                  o_last_row
);

    localparam int NL      = wvo_pkg::NUM_LANES;
    localparam int DIV_LAT = QUAT_FRAC_BITS + 2;

    // saturating negation for the skew entries
    function automatic wvo_pkg::t_word neg_sat(input wvo_pkg::t_word v);
        if (v == 32'sh8000_0000) begin
            neg_sat = 32'sh7fff_ffff;
        end else begin
            neg_sat = -v;
        end
    endfunction

    // ---------------- acceptance ----------------
    logic r_busy;
    logic accept;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= accept;
        end
    end

    // ---------------- stage a: input register ----------------
    logic           r_a_valid;
    wvo_pkg::t_word r_a_x, r_a_y, r_a_z, r_a_w;
    wvo_pkg::t_vec  r_a_v;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_x    <= i_quat_x;
            r_a_y    <= i_quat_y;
            r_a_z    <= i_quat_z;
            r_a_w    <= i_quat_w;
            r_a_v[0] <= i_fixed_vel_x;
            r_a_v[1] <= i_fixed_vel_y;
            r_a_v[2] <= i_fixed_vel_z;
        end
    end

    // ---------------- stage b: prescale ----------------
    // any component beyond +-1.0 in Q2.30 halves all four, so squares stay in range
    logic           r_b_valid;
    wvo_pkg::t_word r_b_x, r_b_y, r_b_z, r_b_w;
    wvo_pkg::t_vec  r_b_v;
    logic           big;

    function automatic logic out_of_range(input wvo_pkg::t_word v);
        out_of_range = (v > 32'sd1073741824) || (v < -32'sd1073741824);
    endfunction

    assign big = out_of_range(r_a_x) || out_of_range(r_a_y)
              || out_of_range(r_a_z) || out_of_range(r_a_w);

    always_ff @(posedge i_clk) begin
        r_b_x <= big ? (r_a_x >>> 1) : r_a_x;
        r_b_y <= big ? (r_a_y >>> 1) : r_a_y;
        r_b_z <= big ? (r_a_z >>> 1) : r_a_z;
        r_b_w <= big ? (r_a_w >>> 1) : r_a_w;
        r_b_v <= r_a_v;
    end

    // ---------------- stage c: quadratic products ----------------
    logic               r_c_valid;
    logic signed [63:0] r_c_xx, r_c_yy, r_c_zz, r_c_ww;
    logic signed [63:0] r_c_xy, r_c_wz, r_c_xz, r_c_wy, r_c_yz, r_c_wx;
    wvo_pkg::t_vec      r_c_v;

    always_ff @(posedge i_clk) begin
        r_c_xx <= r_b_x * r_b_x;
        r_c_yy <= r_b_y * r_b_y;
        r_c_zz <= r_b_z * r_b_z;
        r_c_ww <= r_b_w * r_b_w;
        r_c_xy <= r_b_x * r_b_y;
        r_c_wz <= r_b_w * r_b_z;
        r_c_xz <= r_b_x * r_b_z;
        r_c_wy <= r_b_w * r_b_y;
        r_c_yz <= r_b_y * r_b_z;
        r_c_wx <= r_b_w * r_b_x;
        r_c_v  <= r_b_v;
    end

    // ---------------- stage d: pair sums ----------------
    logic               r_d_valid;
    logic signed [63:0] r_d_a, r_d_b, r_d_c, r_d_d;
    logic signed [63:0] r_d_xy_p, r_d_xy_m, r_d_xz_p, r_d_xz_m, r_d_yz_p, r_d_yz_m;
    wvo_pkg::t_vec      r_d_v;

    always_ff @(posedge i_clk) begin
        r_d_a    <= r_c_ww + r_c_xx;
        r_d_b    <= r_c_yy + r_c_zz;
        r_d_c    <= r_c_ww - r_c_xx;
        r_d_d    <= r_c_yy - r_c_zz;
        r_d_xy_p <= r_c_xy + r_c_wz;
        r_d_xy_m <= r_c_xy - r_c_wz;
        r_d_xz_p <= r_c_xz + r_c_wy;
        r_d_xz_m <= r_c_xz - r_c_wy;
        r_d_yz_p <= r_c_yz + r_c_wx;
        r_d_yz_m <= r_c_yz - r_c_wx;
        r_d_v    <= r_c_v;
    end

    // ---------------- stage e: norm, numerators, sign and magnitude ----------------
    // lanes are the transposed rotation in row-major order
    logic signed [63:0] num [NL];
    logic [63:0]        n_sum;

    always_comb begin
        n_sum  = r_d_a + r_d_b;
        num[0] = r_d_a - r_d_b;
        num[1] = r_d_xy_p <<< 1;
        num[2] = r_d_xz_m <<< 1;
        num[3] = r_d_xy_m <<< 1;
        num[4] = r_d_c + r_d_d;
        num[5] = r_d_yz_p <<< 1;
        num[6] = r_d_xz_p <<< 1;
        num[7] = r_d_yz_m <<< 1;
        num[8] = r_d_c - r_d_d;
    end

    wvo_pkg::t_div_ctl r_e_ctl;
    wvo_pkg::t_mag     r_e_n;
    wvo_pkg::t_mag     r_e_mag [NL];
    logic [NL-1:0]     r_e_neg;
    wvo_pkg::t_vec     r_e_v;

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NL; l++) begin
            r_e_mag[l] <= num[l][63] ? 63'(-num[l]) : 63'(num[l]);
            r_e_neg[l] <= num[l][63];
        end
        r_e_n <= n_sum[62:0];
        r_e_v <= r_d_v;
    end

    // control of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_ctl   <= '0;
        end else begin
            r_a_valid     <= accept;
            r_b_valid     <= r_a_valid;
            r_c_valid     <= r_b_valid;
            r_d_valid     <= r_c_valid;
            r_e_ctl.valid <= r_d_valid;
            r_e_ctl.zero  <= (n_sum == 64'd0);
        end
    end

    // ---------------- divider ----------------
    wvo_pkg::t_div_ctl div_ctl;
    wvo_pkg::t_word    div_rt [NL];

    wvo_divider #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_e_ctl),
        .i_n     (r_e_n),
        .i_mag   (r_e_mag),
        .i_neg   (r_e_neg),
        .o_ctl   (div_ctl),
        .o_rt    (div_rt)
    );

    // velocity delay line matching the divider
    wvo_pkg::t_vec r_vd [DIV_LAT];

    always_ff @(posedge i_clk) begin
        r_vd[0] <= r_e_v;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_vd[k] <= r_vd[k-1];
        end
    end

    // ---------------- stage g: rotation products ----------------
    logic               r_g_valid;
    logic signed [63:0] r_g_p [NL];
    wvo_pkg::t_word     r_g_rt [6];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_g_p[i*3+j] <= div_rt[i*3+j] * r_vd[DIV_LAT-1][j];
            end
        end
        for (int l = 0; l < 6; l++) begin
            r_g_rt[l] <= div_rt[l];
        end
    end

    // ---------------- stage h: dot products with rounding offset ----------------
    localparam logic signed [63:0] RND = 64'sd1 <<< (QUAT_FRAC_BITS - 1);

    logic               r_h_valid;
    logic signed [63:0] r_h_acc [3];
    wvo_pkg::t_word     r_h_rt  [6];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_h_acc[i] <= r_g_p[i*3] + r_g_p[i*3+1] + r_g_p[i*3+2] + RND;
        end
        r_h_rt <= r_g_rt;
    end

    // ---------------- stage f: scale and saturate, held for both rows ----------------
    logic               r_f_valid;
    wvo_pkg::t_word     r_f_vb [3];
    wvo_pkg::t_word     r_f_rt [6];
    logic signed [63:0] vb_wide [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vb_wide[i] = r_h_acc[i] >>> QUAT_FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_h_valid) begin
            for (int i = 0; i < 3; i++) begin
                if (vb_wide[i] > 64'sd2147483647) begin
                    r_f_vb[i] <= 32'sh7fff_ffff;
                end else if (vb_wide[i] < -64'sd2147483648) begin
                    r_f_vb[i] <= 32'sh8000_0000;
                end else begin
                    r_f_vb[i] <= 32'(vb_wide[i]);
                end
            end
            r_f_rt <= r_h_rt;
        end
    end

    // ---------------- output rows ----------------
    // row 0 follows a valid stage f item; row 1 comes from the same held item next cycle
    logic r_pend;
    logic r_o_valid;
    logic r_o_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
            r_h_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
            r_o_row   <= 1'b0;
        end else begin
            r_g_valid <= div_ctl.valid;
            r_h_valid <= r_g_valid;
            r_f_valid <= r_h_valid;
            r_pend    <= r_f_valid;
            r_o_valid <= r_f_valid || r_pend;
            r_o_row   <= !r_f_valid && r_pend;
        end
    end

    wvo_pkg::t_word r_o_bv, r_o_r0, r_o_r1, r_o_r2, r_o_s0, r_o_s1, r_o_s2;

    always_ff @(posedge i_clk) begin
        if (r_f_valid) begin
            r_o_bv <= r_f_vb[0];
            r_o_r0 <= r_f_rt[0];
            r_o_r1 <= r_f_rt[1];
            r_o_r2 <= r_f_rt[2];
            r_o_s0 <= 32'sd0;
            r_o_s1 <= neg_sat(r_f_vb[2]);
            r_o_s2 <= r_f_vb[1];
        end else begin
            r_o_bv <= r_f_vb[1];
            r_o_r0 <= r_f_rt[3];
            r_o_r1 <= r_f_rt[4];
            r_o_r2 <= r_f_rt[5];
            r_o_s0 <= r_f_vb[2];
            r_o_s1 <= 32'sd0;
            r_o_s2 <= neg_sat(r_f_vb[0]);
        end
    end

    assign o_valid         = r_o_valid;
    assign o_row_index     = r_o_row;
    assign o_last_row      = r_o_row;
    assign o_body_velocity = r_o_bv;
    assign o_rot_col0      = r_o_r0;
    assign o_rot_col1      = r_o_r1;
    assign o_rot_col2      = r_o_r2;
    assign o_skew_col0     = r_o_s0;
    assign o_skew_col1     = r_o_s1;
    assign o_skew_col2     = r_o_s2;

endmodule
